### rtl/ptd_pkg.sv
// ---------------------------------------------------------------------------
// ptd_pkg: shared types and constants
// Beat types, operation codes and the control group that drives the slot cells.
// ---------------------------------------------------------------------------
package ptd_pkg;

	localparam int TASK_SLOTS = 8;
	localparam int MAX_FIRED  = 8;
	localparam int FOUND_W    = $clog2(MAX_FIRED + 1);

	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_CREATE  = 3'd1;
	localparam logic [2:0] OP_SUSPEND = 3'd2;
	localparam logic [2:0] OP_RESUME  = 3'd3;
	localparam logic [2:0] OP_DELETE  = 3'd4;

	typedef struct packed {
		logic [2:0]  op;
		logic [2:0]  task_id;
		logic [15:0] period;
		logic [15:0] first_delay;
	} ptd_in_t;

	typedef struct packed {
		logic [2:0] fired_task;
		logic       last;
	} ptd_out_t;

	typedef struct packed {
		logic        wr;
		logic        shift;
		logic [2:0]  op;
		logic [2:0]  task_id;
		logic [15:0] period;
		logic [15:0] first_delay;
	} ptd_ctl_t;

endpackage

### rtl/ptd_cell.sv
// ---------------------------------------------------------------------------
// ptd_cell: one task slot
// Holds valid, ready, period and countdown; on a tick it settles its due bit,
// then shifts due bits toward slot 0 one position per cycle.
// ---------------------------------------------------------------------------
module ptd_cell #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ptd_pkg::ptd_ctl_t ctl,
	input  logic            fire_in,
	output logic            fire_out
);
	import ptd_pkg::*;

	logic        valid_q;
	logic        ready_q;
	logic        fire_q;
	logic [15:0] period_q;
	logic [15:0] count_q;
	logic        sel;
	logic        tick;
	logic        live;

	assign sel  = ctl.wr && (int'(ctl.task_id) == IDX);
	assign tick = ctl.wr && (ctl.op == OP_TICK);
	assign live = valid_q && ready_q;
	assign fire_out = fire_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ready_q <= 1'b0;
			fire_q  <= 1'b0;
		end else begin
			if (tick) begin
				fire_q <= live && (count_q == 16'd0);
			end else if (ctl.shift) begin
				fire_q <= fire_in;
			end
			if (sel) begin
				unique case (ctl.op)
					OP_CREATE: begin
						valid_q <= 1'b1;
						ready_q <= 1'b1;
					end
					OP_SUSPEND: ready_q <= 1'b0;
					OP_RESUME:  ready_q <= 1'b1;
					OP_DELETE:  valid_q <= 1'b0;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel && ctl.op == OP_CREATE) begin
			period_q <= ctl.period;
			count_q  <= ctl.first_delay;
		end else if (tick && live) begin
			if (count_q == 16'd0)
				count_q <= period_q - 16'd1;
			else
				count_q <= count_q - 16'd1;
		end
	end

endmodule

### rtl/periodic_task_dispatcher_top.sv
// ---------------------------------------------------------------------------
// periodic_task_dispatcher_top: time-triggered task slot table
// Create, suspend, resume and delete leave busy low; a tick walks the slots
// and reports each fired slot as one result beat.
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Create, suspend,
// resume, delete and unknown codes finish in the accept cycle and leave busy
// low. A tick updates the countdown of each valid, ready slot in the accept
// cycle, then the due bits shift out of the cell row one slot per cycle, so busy
// stays high through the walk and flush states. Each fired slot appears on
// result for one cycle with strobe high, in slot order, at most eight per tick,
// with last set on the final one; the receiver cannot stall, so beats must be
// taken as they come. A tick with nothing due gives no beat.
module periodic_task_dispatcher_top #(
	parameter int TASK_SLOTS = ptd_pkg::TASK_SLOTS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ptd_pkg::ptd_in_t  item,
	output logic             strobe,
	output ptd_pkg::ptd_out_t result
);
	import ptd_pkg::*;

	localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

	typedef enum logic [1:0] {S_IDLE, S_WALK, S_FLUSH} state_t;

	state_t             state_q;
	logic [IW-1:0]      idx_q;
	logic [FOUND_W-1:0] found_q;
	logic               pend_v_q;
	logic [2:0]         pend_q;
	logic               strobe_q;
	ptd_out_t           result_q;
	ptd_ctl_t           ctl;
	logic [TASK_SLOTS-1:0] fire;
	logic               accept;
	logic               hit;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;
	assign hit    = fire[0] && (found_q < FOUND_W'(MAX_FIRED));

	always_comb begin
		ctl.wr          = accept;
		ctl.shift       = (state_q == S_WALK);
		ctl.op          = item.op;
		ctl.task_id     = item.task_id;
		ctl.period      = item.period;
		ctl.first_delay = item.first_delay;
	end

	for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
		logic nxt;
		if (i == TASK_SLOTS - 1) begin : g_end
			assign nxt = 1'b0;
		end else begin : g_mid
			assign nxt = fire[i+1];
		end
		ptd_cell #(.IDX(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.fire_in (nxt),
			.fire_out(fire[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			found_q  <= '0;
			pend_v_q <= 1'b0;
			pend_q   <= '0;
			strobe_q <= 1'b0;
			result_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && item.op == OP_TICK) begin
						state_q  <= S_WALK;
						idx_q    <= '0;
						found_q  <= '0;
						pend_v_q <= 1'b0;
					end
				end
				S_WALK: begin
					if (hit) begin
						if (pend_v_q) begin
							strobe_q            <= 1'b1;
							result_q.fired_task <= pend_q;
							result_q.last       <= 1'b0;
						end
						pend_q   <= 3'(idx_q);
						pend_v_q <= 1'b1;
						found_q  <= found_q + FOUND_W'(1);
					end
					if (idx_q == IW'(TASK_SLOTS - 1))
						state_q <= S_FLUSH;
					else
						idx_q <= idx_q + IW'(1);
				end
				S_FLUSH: begin
					if (pend_v_q) begin
						strobe_q            <= 1'b1;
						result_q.fired_task <= pend_q;
						result_q.last       <= 1'b1;
					end
					pend_v_q <= 1'b0;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result beat without a tick in progress");

	a_found_cap: assert property (@(posedge clk) disable iff (!arst_n)
		found_q <= FOUND_W'(MAX_FIRED))
		else $error("fired count above limit");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.op == OP_TICK) |=> busy)
		else $error("tick taken without walk");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |=> !strobe)
		else $error("beat after last");

	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q)
		else $error("pending beat left behind");

endmodule
